FILE: hw/rtl/tml_pkg.sv
// Shared types, codes and character classes of the TeX math lexer.
package tml_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int MAX_RESULTS       = 3;
  localparam int CANDIDATES        = 5;

  typedef enum logic [3:0] {
    KIND_SPACE   = 4'd0,
    KIND_CMD     = 4'd1,
    KIND_OTHER   = 4'd2,
    KIND_LBRACE  = 4'd3,
    KIND_RBRACE  = 4'd4,
    KIND_LBRACK  = 4'd5,
    KIND_RBRACK  = 4'd6,
    KIND_COMMENT = 4'd7,
    KIND_DOLLAR  = 4'd8,
    KIND_DDOLLAR = 4'd9,
    KIND_AMP     = 4'd10,
    KIND_SUB     = 4'd11,
    KIND_SUP     = 4'd12,
    KIND_ALNUM   = 4'd13
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SPACE,
    MODE_BSLASH,
    MODE_NAME,
    MODE_CHAR_DEC,
    MODE_CHAR_QUOTE,
    MODE_CHAR_HEX,
    MODE_COMMENT,
    MODE_DOLLAR,
    MODE_ALNUM
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] prog;
    logic       after_cmd;
    logic       stopped;
  } ctl_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_C  = 8'h63;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || is_alpha(b);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic is_escaped(input logic [7:0] b);
    return b == CH_DOLLAR || b == CH_PCT || b == CH_AMP || b == CH_UNDER ||
           b == CH_LBRACE || b == CH_RBRACE;
  endfunction

  function automatic logic is_symbol(input logic [7:0] b);
    logic r;
    case (b)
      8'h20, 8'h2C, 8'h3A, 8'h3B, 8'h21, 8'h3E, 8'h2E, 8'h5E, 8'h27,
      8'h7E, 8'h60, 8'h3D, 8'h22, 8'h5B, 8'h5D, 8'h5C, 8'h7C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_AMP:    k = KIND_AMP;
      CH_UNDER:  k = KIND_SUB;
      CH_CARET:  k = KIND_SUP;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/tex_math_lexer.sv
// TeX math lexer top level: input register, lexer state and token buffer.
//
// Input channel: in_valid / in_stall carry text_byte and end_of_text, one
// text byte per word. Output channel: out_valid / out_stall carry one token
// per word (token_kind, token_start, token_length, orphan_error,
// last_of_run). A byte yields zero to three tokens; last_of_run marks the
// final token of a byte.
// A byte is taken into the input register; the lexer state logic turns it
// into tokens that are written to the token buffer and read out from it.
// Throughput: one byte per cycle while each byte yields at most one token
// and out_stall is low; a byte that yields more holds the next byte back
// until its last token is taken. Space tokens are held until the next
// byte is seen, so they come out with that byte.
// Reset (rst, synchronous) empties both stages and starts a new text at
// offset 0. When the receiver stalls, the token buffer holds and the input
// register holds its byte; in_stall rises only while that byte waits.
module tex_math_lexer #(
  parameter int POSITION_BITS = tml_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = tml_pkg::LENGTH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               text_byte,
  input  logic                     end_of_text,
  output logic                     out_valid,
  input  logic                     out_stall,
  output tml_pkg::kind_t           token_kind,
  output logic [POSITION_BITS-1:0] token_start,
  output logic [LENGTH_BITS-1:0]   token_length,
  output logic                     orphan_error,
  output logic                     last_of_run
);
  import tml_pkg::*;

  logic                     iv;
  logic [7:0]               ib;
  logic                     ie;

  ctl_t                     ctl;
  logic [POSITION_BITS-1:0] start;
  logic [LENGTH_BITS-1:0]   space_len;
  logic [POSITION_BITS-1:0] pos;

  ctl_t                     ctl_next;
  logic [POSITION_BITS-1:0] start_next;
  logic [LENGTH_BITS-1:0]   space_len_next;
  logic [POSITION_BITS-1:0] pos_next;
  logic [1:0]               step_count;
  kind_t                    step_kind  [MAX_RESULTS];
  logic [POSITION_BITS-1:0] step_start [MAX_RESULTS];
  logic [LENGTH_BITS-1:0]   step_len   [MAX_RESULTS];
  logic                     step_err   [MAX_RESULTS];

  kind_t                    ob_kind  [MAX_RESULTS];
  logic [POSITION_BITS-1:0] ob_start [MAX_RESULTS];
  logic [LENGTH_BITS-1:0]   ob_len   [MAX_RESULTS];
  logic                     ob_err   [MAX_RESULTS];
  logic [1:0]               ocnt;
  logic [1:0]               oidx;
  logic [1:0]               sel;

  logic out_take;
  logic consume;

  tml_step #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_step (
    .cur_ctl       (ctl),
    .cur_start     (start),
    .cur_space_len (space_len),
    .cur_pos       (pos),
    .text_byte     (ib),
    .end_of_text   (ie),
    .next_ctl      (ctl_next),
    .next_start    (start_next),
    .next_space_len(space_len_next),
    .next_pos      (pos_next),
    .res_count     (step_count),
    .res_kind      (step_kind),
    .res_start     (step_start),
    .res_len       (step_len),
    .res_err       (step_err)
  );

  assign out_valid = (oidx != ocnt);
  assign out_take  = out_valid && !out_stall;
  assign consume   = iv && ((oidx == ocnt) || (out_take && (oidx + 2'd1 == ocnt)));
  assign in_stall  = iv && !consume;

  assign sel          = (oidx == 2'd3) ? 2'd0 : oidx;
  assign token_kind   = ob_kind[sel];
  assign token_start  = ob_start[sel];
  assign token_length = ob_len[sel];
  assign orphan_error = ob_err[sel];
  assign last_of_run  = (oidx + 2'd1 == ocnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && !in_stall) begin
      iv <= 1'b1;
    end else if (consume) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib <= text_byte;
      ie <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= '{mode: MODE_IDLE, prog: '0, after_cmd: 1'b0, stopped: 1'b0};
      start     <= '0;
      space_len <= '0;
      pos       <= '0;
      ocnt      <= '0;
      oidx      <= '0;
    end else if (consume) begin
      ctl       <= ctl_next;
      start     <= start_next;
      space_len <= space_len_next;
      pos       <= pos_next;
      ocnt      <= step_count;
      oidx      <= '0;
    end else if (out_take) begin
      oidx      <= oidx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      ob_kind  <= step_kind;
      ob_start <= step_start;
      ob_len   <= step_len;
      ob_err   <= step_err;
    end
  end

endmodule

FILE: hw/rtl/tml_step.sv
// Next-state and token logic for one text byte of the lexer.
module tml_step #(
  parameter int POSITION_BITS = tml_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = tml_pkg::LENGTH_BITS_DEF
) (
  input  tml_pkg::ctl_t             cur_ctl,
  input  logic [POSITION_BITS-1:0]  cur_start,
  input  logic [LENGTH_BITS-1:0]    cur_space_len,
  input  logic [POSITION_BITS-1:0]  cur_pos,
  input  logic [7:0]                text_byte,
  input  logic                      end_of_text,
  output tml_pkg::ctl_t             next_ctl,
  output logic [POSITION_BITS-1:0]  next_start,
  output logic [LENGTH_BITS-1:0]    next_space_len,
  output logic [POSITION_BITS-1:0]  next_pos,
  output logic [1:0]                res_count,
  output tml_pkg::kind_t            res_kind  [tml_pkg::MAX_RESULTS],
  output logic [POSITION_BITS-1:0]  res_start [tml_pkg::MAX_RESULTS],
  output logic [LENGTH_BITS-1:0]    res_len   [tml_pkg::MAX_RESULTS],
  output logic                      res_err   [tml_pkg::MAX_RESULTS]
);
  import tml_pkg::*;

  localparam int P = POSITION_BITS;
  localparam int L = LENGTH_BITS;
  localparam logic [L-1:0] LMAX = {L{1'b1}};

  function automatic logic [L-1:0] span(input logic [P-1:0] s, input logic [P-1:0] e);
    logic [P-1:0]   d;
    logic [P+L-1:0] dw;
    d  = e - s;
    dw = {{L{1'b0}}, d};
    if (dw > {{P{1'b0}}, LMAX}) return LMAX;
    return dw[L-1:0];
  endfunction

  logic             cv [CANDIDATES];
  kind_t            ck [CANDIDATES];
  logic [P-1:0]     cs [CANDIDATES];
  logic [L-1:0]     cl [CANDIDATES];
  logic             ce [CANDIDATES];

  ctl_t         c;
  logic [P-1:0] st;
  logic [L-1:0] hl;
  logic [L-1:0] sl;
  logic [P-1:0] nxt;
  logic [P-1:0] fpos;
  logic         do_begin;
  logic [1:0]   n;
  logic [7:0]   b;

  always_comb begin
    c        = cur_ctl;
    st       = cur_start;
    hl       = cur_space_len;
    next_pos = cur_pos;
    b        = text_byte;
    nxt      = cur_pos + P'(1);
    fpos     = (b == CH_NUL) ? cur_pos : nxt;
    do_begin = 1'b0;
    sl       = '0;
    for (int i = 0; i < CANDIDATES; i++) begin
      cv[i] = 1'b0;
      ck[i] = KIND_SPACE;
      cs[i] = '0;
      cl[i] = '0;
      ce[i] = 1'b0;
    end

    if (!cur_ctl.stopped) begin
      // close or extend the open token
      if (b != CH_NUL) begin
        unique case (c.mode)
          MODE_SPACE: begin
            if (is_space(b)) begin
              if (b != CH_CR && hl < LMAX) hl = hl + L'(1);
            end else begin
              sl = hl;
              if (sl != '0 && cur_ctl.after_cmd && is_alnum(b)) sl = sl - L'(1);
              if (sl != '0) begin
                cv[0] = 1'b1; ck[0] = KIND_SPACE; cs[0] = st; cl[0] = sl;
              end
              hl = '0;
              c.mode = MODE_IDLE; c.prog = '0;
              do_begin = 1'b1;
            end
          end
          MODE_BSLASH: begin
            if (is_escaped(b)) begin
              cv[0] = 1'b1; ck[0] = KIND_OTHER; cs[0] = st; cl[0] = span(st, nxt);
              c.mode = MODE_IDLE; c.prog = '0;
            end else if (is_symbol(b)) begin
              cv[0] = 1'b1; ck[0] = KIND_CMD; cs[0] = st; cl[0] = span(st, nxt);
              c.mode = MODE_IDLE; c.prog = '0;
            end else if (is_alnum(b)) begin
              c.mode = MODE_NAME;
              c.prog = (b == CH_LOW_C) ? 3'd1 : 3'd0;
            end else begin
              cv[0] = 1'b1; ck[0] = KIND_CMD; cs[0] = st; cl[0] = span(st, cur_pos);
              c.mode = MODE_IDLE; c.prog = '0;
              do_begin = 1'b1;
            end
          end
          MODE_NAME: begin
            if ((c.prog == 3'd1 && b == CH_LOW_H) || (c.prog == 3'd2 && b == CH_LOW_A) ||
                (c.prog == 3'd3 && b == CH_LOW_R)) begin
              c.prog = c.prog + 3'd1;
            end else if (c.prog == 3'd4 && is_digit(b)) begin
              c.mode = MODE_CHAR_DEC;
            end else if (c.prog == 3'd4 && b == CH_QUOTE) begin
              c.mode = MODE_CHAR_QUOTE;
            end else if (is_alnum(b)) begin
              c.prog = '0;
            end else begin
              cv[0] = 1'b1; ck[0] = KIND_CMD; cs[0] = st; cl[0] = span(st, cur_pos);
              c.mode = MODE_IDLE; c.prog = '0;
              do_begin = 1'b1;
            end
          end
          MODE_CHAR_DEC, MODE_CHAR_HEX: begin
            if (!((c.mode == MODE_CHAR_DEC) ? is_digit(b) : is_hex(b))) begin
              cv[0] = 1'b1; ck[0] = KIND_CMD; cs[0] = st; cl[0] = span(st, cur_pos);
              c.mode = MODE_IDLE; c.prog = '0;
              do_begin = 1'b1;
            end
          end
          MODE_CHAR_QUOTE: begin
            if (is_hex(b)) begin
              c.mode = MODE_CHAR_HEX;
            end else begin
              cv[0] = 1'b1; ck[0] = KIND_CMD;   cs[0] = st;        cl[0] = L'(5);
              cv[1] = 1'b1; ck[1] = KIND_OTHER; cs[1] = st + P'(5); cl[1] = L'(1);
              c.mode = MODE_IDLE; c.prog = '0;
              do_begin = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (b == CH_LF) begin
              cv[0] = 1'b1; ck[0] = KIND_COMMENT; cs[0] = st; cl[0] = span(st, nxt);
              c.mode = MODE_IDLE; c.prog = '0;
            end
          end
          MODE_DOLLAR: begin
            cv[0] = 1'b1; cs[0] = st;
            c.mode = MODE_IDLE; c.prog = '0;
            if (b == CH_DOLLAR) begin
              ck[0] = KIND_DDOLLAR; cl[0] = span(st, nxt);
            end else begin
              ck[0] = KIND_DOLLAR; cl[0] = L'(1);
              do_begin = 1'b1;
            end
          end
          MODE_ALNUM: begin
            if (!is_alnum(b)) begin
              cv[0] = 1'b1; ck[0] = KIND_ALNUM; cs[0] = st; cl[0] = span(st, cur_pos);
              c.mode = MODE_IDLE; c.prog = '0;
              do_begin = 1'b1;
            end
          end
          default: begin
            c.mode = MODE_IDLE; c.prog = '0;
            do_begin = 1'b1;
          end
        endcase

        // open a new token at this byte
        if (do_begin) begin
          priority if (is_space(b)) begin
            c.mode = MODE_SPACE; st = cur_pos;
            hl = (b != CH_CR) ? L'(1) : '0;
          end else if (b == CH_BSLASH) begin
            c.mode = MODE_BSLASH; st = cur_pos;
          end else if (b == CH_PCT) begin
            c.mode = MODE_COMMENT; st = cur_pos;
          end else if (b == CH_DOLLAR) begin
            c.mode = MODE_DOLLAR; st = cur_pos;
          end else if (is_alnum(b)) begin
            c.mode = MODE_ALNUM; st = cur_pos;
          end else begin
            cv[2] = 1'b1; ck[2] = single_kind(b); cs[2] = cur_pos; cl[2] = L'(1);
            c.mode = MODE_IDLE; c.prog = '0;
          end
        end
      end

      // end of text or a NUL byte: flush what is open
      if (b == CH_NUL || end_of_text) begin
        unique case (c.mode)
          MODE_BSLASH: begin
            cv[3] = 1'b1; ck[3] = KIND_CMD; cs[3] = st; cl[3] = '0; ce[3] = 1'b1;
          end
          MODE_NAME, MODE_CHAR_DEC, MODE_CHAR_HEX: begin
            cv[3] = 1'b1; ck[3] = KIND_CMD; cs[3] = st; cl[3] = span(st, fpos);
          end
          MODE_CHAR_QUOTE: begin
            cv[3] = 1'b1; ck[3] = KIND_CMD;   cs[3] = st;        cl[3] = L'(5);
            cv[4] = 1'b1; ck[4] = KIND_OTHER; cs[4] = st + P'(5); cl[4] = L'(1);
          end
          MODE_COMMENT: begin
            cv[3] = 1'b1; ck[3] = KIND_COMMENT; cs[3] = st; cl[3] = span(st, fpos);
          end
          MODE_DOLLAR: begin
            cv[3] = 1'b1; ck[3] = KIND_DOLLAR; cs[3] = st; cl[3] = L'(1);
          end
          MODE_ALNUM: begin
            cv[3] = 1'b1; ck[3] = KIND_ALNUM; cs[3] = st; cl[3] = span(st, fpos);
          end
          default: ;
        endcase
        hl = '0;
        c.mode = MODE_IDLE; c.prog = '0;
      end

      if (b == CH_NUL && !end_of_text) c.stopped = 1'b1;
      if (b != CH_NUL && !end_of_text) next_pos = nxt;
    end

    // pack emitted words in order
    n = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_kind[i]  = KIND_SPACE;
      res_start[i] = '0;
      res_len[i]   = '0;
      res_err[i]   = 1'b0;
    end
    for (int i = 0; i < CANDIDATES; i++) begin
      if (cv[i]) begin
        if (n != 2'd3) begin
          res_kind[n]  = ck[i];
          res_start[n] = cs[i];
          res_len[n]   = cl[i];
          res_err[n]   = ce[i];
          n = n + 2'd1;
        end
        c.after_cmd = (ck[i] == KIND_CMD);
      end
    end
    res_count = n;

    if (end_of_text) begin
      c        = '{mode: MODE_IDLE, prog: '0, after_cmd: 1'b0, stopped: 1'b0};
      st       = '0;
      hl       = '0;
      next_pos = '0;
    end

    next_ctl       = c;
    next_start     = st;
    next_space_len = hl;
  end

endmodule
